[hdl/wlm_pkg.sv]
// ----------------------------------------------------------------------------
// wlm_pkg
// types, constants and helper functions of the wordpiece longest-match splitter
// ----------------------------------------------------------------------------
package wlm_pkg;

  // default sizes
  localparam int SLOTS_DEF          = 65536;
  localparam int VOCAB_BYTES_DEF    = 262144;
  localparam int MAX_WORD_CHARS_DEF = 100;

  // most ids returned for one word
  localparam int RESULT_MAX = 64;

  // fnv-1a 64 offset basis; the prime is 2^40 + 0x1b3, applied as shifts
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  // continuation prefix character
  localparam logic [7:0] HASH_CHAR = 8'h23;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOT_MASK    = 2'd0;
  localparam logic [1:0] CFG_UNKNOWN_ID   = 2'd1;
  localparam logic [1:0] CFG_OUT_CAPACITY = 2'd2;

  typedef enum logic [2:0] {
    CMD_WRITE_SLOT = 3'd0,
    CMD_WRITE_BYTE = 3'd1,
    CMD_PUSH_CHAR  = 3'd2,
    CMD_END_WORD   = 3'd3,
    CMD_START_SEQ  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENC,
    ST_KEY_A,
    ST_KEY_B,
    ST_KEY_C,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_CMP,
    ST_HIT,
    ST_MISS,
    ST_EMIT_SET,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_UNK
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [17:0] addr;
    logic        slot_used;
    logic [8:0]  slot_length;
    logic [17:0] slot_offset;
    logic [19:0] slot_token;
    logic [7:0]  token_byte;
    logic [20:0] code_point;
  } in_item_t;

  typedef struct packed {
    logic [19:0] token_id;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        used;
    logic [8:0]  length;
    logic [17:0] offset;
    logic [19:0] token;
  } slot_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  // utf-8 encoding of one code point, byte 0 first
  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.len      = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len      = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

  // one fnv-1a round: xor the byte, multiply by 2^40 + 0x1b3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[hdl/wordpiece_longest_match.sv]
// ----------------------------------------------------------------------------
// wordpiece_longest_match
// greedy longest-match-first wordpiece splitter over a hashed vocabulary
// ----------------------------------------------------------------------------
// Characters of one word are pushed one beat each and utf-8 encoded into a
// word byte buffer (a push stalls the input while its bytes are written).
// At end of word the word is cut from the left into the longest pieces found
// in the vocabulary; every piece after the first is looked up with a "##"
// prefix. Each lookup attempt fetches the character offsets and hashes the
// L key bytes, then per probe reads a slot and, when the slot length equals
// L, compares the key bytes with the byte store, all paced by the single
// read port of the slot table, byte store and word buffer. Ids leave through
// an output register, each read from the id store before it is written out.
// After reset the slot table is swept to unoccupied, one slot per cycle,
// while the input is stalled; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module wordpiece_longest_match
  import wlm_pkg::*;
#(
  parameter int SLOTS          = SLOTS_DEF,
  parameter int VOCAB_BYTES    = VOCAB_BYTES_DEF,
  parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);

  localparam int SAW  = $clog2(SLOTS);
  localparam int VAW  = $clog2(VOCAB_BYTES);
  localparam int CW   = $clog2(MAX_WORD_CHARS + 1);
  localparam int CCW  = $clog2(MAX_WORD_CHARS + 2);
  localparam int CIW  = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
  localparam int WBD  = 4 * MAX_WORD_CHARS;
  localparam int BW   = $clog2(WBD + 1);
  localparam int WBAW = $clog2(WBD);
  localparam int KW   = $clog2(WBD + 3);

  // memories
  slot_t       slot_mem [SLOTS];
  logic [7:0]  vb_mem   [VOCAB_BYTES];
  logic [7:0]  wb_mem   [WBD];
  logic [BW-1:0] off_mem [MAX_WORD_CHARS];
  logic [19:0] pc_mem   [MAX_WORD_CHARS];

  // memory ports
  logic            slot_we;
  logic [SAW-1:0]  slot_wa, slot_ra;
  slot_t           slot_wd, slot_rd_q;
  logic            vb_we;
  logic [VAW-1:0]  vb_wa, vb_ra;
  logic [7:0]      vb_wd, vb_rd_q;
  logic            wb_we;
  logic [WBAW-1:0] wb_wa, wb_ra;
  logic [7:0]      wb_wd, wb_rd_q;
  logic            off_we;
  logic [CIW-1:0]  off_wa, off_ra;
  logic [BW-1:0]   off_wd, off_rd_q;
  logic            pc_we;
  logic [CIW-1:0]  pc_wa, pc_ra;
  logic [19:0]     pc_wd, pc_rd_q;

  // control and datapath registers
  state_e          state_q, state_d;
  logic [SAW-1:0]  clr_q, clr_d;
  logic [15:0]     slot_mask_q;
  logic [19:0]     unk_q;
  logic [15:0]     cap_q;
  logic [15:0]     emitted_q, emitted_d;
  logic [CCW-1:0]  ccnt_q, ccnt_d;
  logic [BW-1:0]   wbcnt_q, wbcnt_d;
  logic [3:0][7:0] enc_q, enc_d;
  logic [2:0]      elen_q, elen_d;
  logic [1:0]      ek_q, ek_d;
  logic [CW-1:0]   nch_q, nch_d;
  logic [BW-1:0]   tot_q, tot_d;
  logic [CW-1:0]   start_q, start_d;
  logic [CW-1:0]   end_q, end_d;
  logic [CW-1:0]   npc_q, npc_d;
  logic [BW-1:0]   bstart_q, bstart_d;
  logic [KW-1:0]   klen_q, klen_d;
  logic            pre_q, pre_d;
  logic [63:0]     h_q, h_d;
  logic [KW-1:0]   kcnt_q, kcnt_d;
  logic            pv_q, pv_d;
  logic            ph_q, ph_d;
  logic            oob_q, oob_d;
  logic [15:0]     pidx_q, pidx_d;
  logic [16:0]     pcnt_q, pcnt_d;
  logic [17:0]     soff_q, soff_d;
  logic [19:0]     stok_q, stok_d;
  logic [6:0]      nemit_q, nemit_d;
  logic [6:0]      ej_q, ej_d;
  logic            ov_q, ov_d;
  out_item_t       od_q, od_d;

  // shared decode
  logic            in_acc;
  logic            out_free;
  logic [KW-1:0]   pre2;
  logic            key_is_hash;
  logic [BW-1:0]   key_addr;
  logic [7:0]      key_byte;
  logic [18:0]     vat;
  logic            vat_oob;
  logic            key_done;
  logic            cmp_bad;
  logic            probe_over;
  logic            len_same;
  utf8_t           enc_w;
  logic [BW-1:0]   bend;
  logic [15:0]     avail;
  logic [15:0]     take;

  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !ov_q || !out_stall_i;
  assign pre2        = pre_q ? KW'(2) : '0;
  assign key_is_hash = kcnt_q < pre2;
  assign key_addr    = bstart_q + BW'(kcnt_q) - BW'(pre2);
  // prefix bytes are supplied as constants, the word buffer supplies the rest
  assign key_byte    = ph_q ? HASH_CHAR : wb_rd_q;
  assign vat         = {1'b0, soff_q} + 19'(kcnt_q);
  assign vat_oob     = 32'(vat) >= 32'(VOCAB_BYTES);
  assign key_done    = (kcnt_q == klen_q) && !pv_q;
  assign cmp_bad     = pv_q && (oob_q || (vb_rd_q != key_byte));
  assign probe_over  = (pcnt_q > {1'b0, slot_mask_q}) || (32'(pidx_q) >= 32'(SLOTS));
  assign len_same    = 16'(slot_rd_q.length) == 16'(klen_q);
  assign enc_w       = utf8_enc(in_data_i.code_point);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SAW'(SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_PUSH_CHAR: begin
              if (32'(ccnt_q) < 32'(MAX_WORD_CHARS)) state_d = ST_ENC;
            end
            CMD_END_WORD: begin
              if (ccnt_q == '0 || emitted_q >= cap_q) state_d = ST_IDLE;
              else if (32'(ccnt_q) > 32'(MAX_WORD_CHARS)) state_d = ST_UNK;
              else state_d = ST_KEY_A;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ENC: begin
        if (ek_q == 2'(elen_q - 3'd1)) state_d = ST_IDLE;
      end
      ST_KEY_A: state_d = ST_KEY_B;
      ST_KEY_B: state_d = ST_KEY_C;
      ST_KEY_C: state_d = ST_HASH;
      ST_HASH: begin
        if (key_done) state_d = ST_PROBE_RD;
      end
      ST_PROBE_RD: begin
        state_d = probe_over ? ST_MISS : ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (!slot_rd_q.used) state_d = ST_MISS;
        else if (!len_same) state_d = ST_PROBE_RD;
        else state_d = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_bad) state_d = ST_PROBE_RD;
        else if (key_done) state_d = ST_HIT;
      end
      ST_HIT: begin
        state_d = (end_q == nch_q) ? ST_EMIT_SET : ST_KEY_A;
      end
      ST_MISS: begin
        // shorten the candidate by one character, or give up on the word
        state_d = (32'(end_q) > 32'(start_q) + 1) ? ST_KEY_A : ST_UNK;
      end
      ST_EMIT_SET: state_d = ST_EMIT_RD;
      ST_EMIT_RD:  state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) state_d = (ej_q == nemit_q - 7'd1) ? ST_IDLE : ST_EMIT_RD;
      end
      ST_UNK: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_d     = clr_q;
    emitted_d = emitted_q;
    ccnt_d    = ccnt_q;
    wbcnt_d   = wbcnt_q;
    enc_d     = enc_q;
    elen_d    = elen_q;
    ek_d      = ek_q;
    nch_d     = nch_q;
    tot_d     = tot_q;
    start_d   = start_q;
    end_d     = end_q;
    npc_d     = npc_q;
    bstart_d  = bstart_q;
    klen_d    = klen_q;
    pre_d     = pre_q;
    h_d       = h_q;
    kcnt_d    = kcnt_q;
    pv_d      = pv_q;
    ph_d      = ph_q;
    oob_d     = oob_q;
    pidx_d    = pidx_q;
    pcnt_d    = pcnt_q;
    soff_d    = soff_q;
    stok_d    = stok_q;
    nemit_d   = nemit_q;
    ej_d      = ej_q;
    ov_d      = ov_q && out_stall_i;
    od_d      = od_q;
    bend      = '0;
    avail     = '0;
    take      = '0;

    slot_we = 1'b0;
    slot_wa = SAW'(in_data_i.addr);
    slot_wd = {in_data_i.slot_used, in_data_i.slot_length,
               in_data_i.slot_offset, in_data_i.slot_token};
    slot_ra = SAW'(pidx_q);
    vb_we   = 1'b0;
    vb_wa   = VAW'(in_data_i.addr);
    vb_wd   = in_data_i.token_byte;
    vb_ra   = VAW'(vat);
    wb_we   = 1'b0;
    wb_wa   = WBAW'(wbcnt_q);
    wb_wd   = enc_q[ek_q];
    wb_ra   = WBAW'(key_addr);
    off_we  = 1'b0;
    off_wa  = CIW'(ccnt_q);
    off_wd  = wbcnt_q;
    off_ra  = CIW'(start_q);
    pc_we   = 1'b0;
    pc_wa   = CIW'(npc_q);
    pc_wd   = stok_q;
    pc_ra   = CIW'(ej_q);

    case (state_q)
      ST_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        slot_wd = '0;
        clr_d   = clr_q + SAW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_WRITE_SLOT: begin
              slot_we = 32'(in_data_i.addr) < 32'(SLOTS);
            end
            CMD_WRITE_BYTE: begin
              vb_we = 32'(in_data_i.addr) < 32'(VOCAB_BYTES);
            end
            CMD_PUSH_CHAR: begin
              if (32'(ccnt_q) < 32'(MAX_WORD_CHARS)) begin
                off_we = 1'b1;
                enc_d  = enc_w.bytes;
                elen_d = enc_w.len;
                ek_d   = '0;
                ccnt_d = ccnt_q + CCW'(1);
              end else begin
                // overlong word: saturate past the limit
                ccnt_d = CCW'(MAX_WORD_CHARS + 1);
              end
            end
            CMD_END_WORD: begin
              nch_d   = CW'(ccnt_q);
              tot_d   = wbcnt_q;
              start_d = '0;
              end_d   = CW'(ccnt_q);
              npc_d   = '0;
              ccnt_d  = '0;
              wbcnt_d = '0;
            end
            CMD_START_SEQ: begin
              emitted_d = '0;
              ccnt_d    = '0;
              wbcnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ENC: begin
        wb_we   = 1'b1;
        wbcnt_d = wbcnt_q + BW'(1);
        ek_d    = ek_q + 2'd1;
      end
      ST_KEY_A: begin
        off_ra = CIW'(start_q);
      end
      ST_KEY_B: begin
        bstart_d = (start_q == '0) ? '0 : off_rd_q;
        off_ra   = (end_q == nch_q) ? '0 : CIW'(end_q);
      end
      ST_KEY_C: begin
        bend   = (end_q == nch_q) ? tot_q : off_rd_q;
        pre_d  = start_q != '0;
        klen_d = KW'(bend - bstart_q) + ((start_q != '0) ? KW'(2) : KW'(0));
        h_d    = FNV_BASIS;
        kcnt_d = '0;
        pv_d   = 1'b0;
      end
      ST_HASH: begin
        // fetch one key byte per cycle, fold the one fetched before
        if (kcnt_q < klen_q) begin
          wb_ra  = WBAW'(key_addr);
          pv_d   = 1'b1;
          ph_d   = key_is_hash;
          kcnt_d = kcnt_q + KW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) h_d = fnv_step(h_q, key_byte);
        if (key_done) begin
          pidx_d = h_q[15:0] & slot_mask_q;
          pcnt_d = '0;
        end
      end
      ST_PROBE_RD: begin
        slot_ra = SAW'(pidx_q);
      end
      ST_PROBE_CHK: begin
        if (slot_rd_q.used && !len_same) begin
          pidx_d = (pidx_q + 16'd1) & slot_mask_q;
          pcnt_d = pcnt_q + 17'd1;
        end
        soff_d = slot_rd_q.offset;
        stok_d = slot_rd_q.token;
        kcnt_d = '0;
        pv_d   = 1'b0;
      end
      ST_CMP: begin
        if (kcnt_q < klen_q) begin
          vb_ra  = VAW'(vat);
          wb_ra  = WBAW'(key_addr);
          pv_d   = 1'b1;
          ph_d   = key_is_hash;
          oob_d  = vat_oob;
          kcnt_d = kcnt_q + KW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (cmp_bad) begin
          // drop the fetch in flight and move to the next slot
          pv_d   = 1'b0;
          pidx_d = (pidx_q + 16'd1) & slot_mask_q;
          pcnt_d = pcnt_q + 17'd1;
        end
      end
      ST_HIT: begin
        pc_we   = 1'b1;
        npc_d   = npc_q + CW'(1);
        start_d = end_q;
        end_d   = nch_q;
      end
      ST_MISS: begin
        end_d = end_q - CW'(1);
      end
      ST_EMIT_SET: begin
        avail = cap_q - emitted_q;
        take  = 16'(npc_q);
        if (take > 16'(RESULT_MAX)) take = 16'(RESULT_MAX);
        if (take > avail) take = avail;
        nemit_d = 7'(take);
        ej_d    = '0;
      end
      ST_EMIT_RD: begin
        pc_ra = CIW'(ej_q);
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          ov_d        = 1'b1;
          od_d.token_id = pc_rd_q;
          od_d.last   = ej_q == nemit_q - 7'd1;
          emitted_d   = emitted_q + 16'd1;
          ej_d        = ej_q + 7'd1;
        end
      end
      ST_UNK: begin
        if (out_free) begin
          ov_d          = 1'b1;
          od_d.token_id = unk_q;
          od_d.last     = 1'b1;
          emitted_d     = emitted_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      slot_mask_q <= 16'hFFFF;
      unk_q       <= '0;
      cap_q       <= 16'hFFFF;
      emitted_q   <= '0;
      ccnt_q      <= '0;
      wbcnt_q     <= '0;
      pv_q        <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      emitted_q <= emitted_d;
      ccnt_q    <= ccnt_d;
      wbcnt_q   <= wbcnt_d;
      pv_q      <= pv_d;
      ov_q      <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOT_MASK:    slot_mask_q <= cfg_data_i[15:0];
          CFG_UNKNOWN_ID:   unk_q       <= cfg_data_i;
          CFG_OUT_CAPACITY: cap_q       <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    enc_q    <= enc_d;
    elen_q   <= elen_d;
    ek_q     <= ek_d;
    nch_q    <= nch_d;
    tot_q    <= tot_d;
    start_q  <= start_d;
    end_q    <= end_d;
    npc_q    <= npc_d;
    bstart_q <= bstart_d;
    klen_q   <= klen_d;
    pre_q    <= pre_d;
    h_q      <= h_d;
    kcnt_q   <= kcnt_d;
    ph_q     <= ph_d;
    oob_q    <= oob_d;
    pidx_q   <= pidx_d;
    pcnt_q   <= pcnt_d;
    soff_q   <= soff_d;
    stok_q   <= stok_d;
    nemit_q  <= nemit_d;
    ej_q     <= ej_d;
    od_q     <= od_d;
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
  end

  // vocabulary byte store
  always_ff @(posedge clk_i) begin
    if (vb_we) vb_mem[vb_wa] <= vb_wd;
    vb_rd_q <= vb_mem[vb_ra];
  end

  // encoded word bytes
  always_ff @(posedge clk_i) begin
    if (wb_we) wb_mem[wb_wa] <= wb_wd;
    wb_rd_q <= wb_mem[wb_ra];
  end

  // byte offset of each character
  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_rd_q <= off_mem[off_ra];
  end

  // matched piece ids
  always_ff @(posedge clk_i) begin
    if (pc_we) pc_mem[pc_wa] <= pc_wd;
    pc_rd_q <= pc_mem[pc_ra];
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

[hdl/wlm_checker.sv]
// ----------------------------------------------------------------------------
// wlm_checker
// port-level checks of the wordpiece splitter, bound to the top level
// ----------------------------------------------------------------------------
module wlm_checker
  import wlm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic [5:0]  beat_cnt_q;
  logic [15:0] open_q;
  logic        out_beat;
  logic        end_beat;
  logic        last_beat;

  assign out_beat  = out_valid_o && !out_stall_i;
  assign last_beat = out_beat && out_data_o.last;
  assign end_beat  = in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_END_WORD);

  // words ended minus words whose final id has left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
      open_q     <= '0;
    end else begin
      if (out_beat) beat_cnt_q <= out_data_o.last ? '0 : beat_cnt_q + 6'd1;
      open_q <= open_q + 16'(end_beat) - 16'(last_beat);
    end
  end

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no more than 64 ids per word
  a_res_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && beat_cnt_q == 6'd63 |-> out_data_o.last)
    else $error("word gave more than 64 ids");

  // inside a word the input waits until the final id
  a_mid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken in the middle of a word");

  // ids only follow an end of word
  a_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != '0)
    else $error("id without an end of word");

endmodule

bind wordpiece_longest_match wlm_checker u_wlm_checker (.*);

[test/wordpiece_longest_match_tb.sv]
// ----------------------------------------------------------------------------
// wordpiece_longest_match_tb
// self-checking bench for the wordpiece longest-match splitter
// ----------------------------------------------------------------------------
// Loads small vocabularies through slot and byte commands, pushes words made
// of a few code points of every utf-8 length, and checks every emitted id
// against an in-bench predictor that hashes, probes and splits the same way.
// Runs through several register settings, random bursts and random stalls.
// ----------------------------------------------------------------------------
module wordpiece_longest_match_tb;
  import wlm_pkg::*;

  localparam int          WATCH_LIMIT = 400000;
  localparam int          SETTLE      = 2000;
  localparam int          HOLD_CYCLES = 3000;
  localparam logic [2:0]  CMD_SPARE   = 3'd5;   // first unused command code

  typedef logic [7:0]  byte_q_t[$];
  typedef logic [20:0] cp_q_t[$];

  // predictor and store of expected ids
  class wordpiece_scoreboard;
    slot_t       slots[SLOTS_DEF];
    logic [7:0]  vocab[int];
    logic [20:0] chars[MAX_WORD_CHARS_DEF];
    int unsigned char_cnt;
    int unsigned emitted;
    int unsigned word_n;
    logic [15:0] slot_mask;
    logic [19:0] unk_id;
    logic [15:0] out_cap;
    out_item_t   expected_ids[$];
    int          errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      char_cnt  = 0;
      emitted   = 0;
      slot_mask = 16'hFFFF;
      unk_id    = '0;
      out_cap   = 16'hFFFF;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] v);
      if (idx == CFG_SLOT_MASK) slot_mask = v[15:0];
      else if (idx == CFG_UNKNOWN_ID) unk_id = v;
      else if (idx == CFG_OUT_CAPACITY) out_cap = v[15:0];
    endfunction

    function byte_q_t utf8_bytes(logic [20:0] cp);
      byte_q_t b;
      if (cp < 21'h80) begin
        b.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
        b.push_back({3'b110, cp[10:6]});
        b.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        b.push_back({4'b1110, cp[15:12]});
        b.push_back({2'b10, cp[11:6]});
        b.push_back({2'b10, cp[5:0]});
      end else begin
        b.push_back({5'b11110, cp[20:18]});
        b.push_back({2'b10, cp[17:12]});
        b.push_back({2'b10, cp[11:6]});
        b.push_back({2'b10, cp[5:0]});
      end
      return b;
    endfunction

    function logic [63:0] fnv_hash(byte_q_t key);
      logic [63:0] h;
      h = FNV_BASIS;
      foreach (key[k]) h = (h ^ {56'd0, key[k]}) * 64'd1099511628211;
      return h;
    endfunction

    function bit find_piece(byte_q_t key, output logic [19:0] id);
      logic [63:0] h;
      logic [63:0] idx;
      slot_t       s;
      bit          same;
      int          at;
      logic [7:0]  v;
      h  = fnv_hash(key);
      id = '0;
      for (longint i = 0; i <= slot_mask; i++) begin
        idx = (h + i) & {48'd0, slot_mask};
        s   = slots[idx[15:0]];
        if (!s.used) return 0;
        if (s.length != key.size()) continue;
        same = 1;
        foreach (key[k]) begin
          at = s.offset + k;
          v  = vocab.exists(at) ? vocab[at] : 8'h00;
          if (at >= VOCAB_BYTES_DEF || v != key[k]) begin
            same = 0;
            break;
          end
        end
        if (same) begin
          id = s.token;
          return 1;
        end
      end
      return 0;
    endfunction

    function void emit_id(logic [19:0] id);
      out_item_t o;
      if (emitted < out_cap && word_n < RESULT_MAX) begin
        o.token_id = id;
        o.last     = 1'b0;
        expected_ids.push_back(o);
        word_n++;
        emitted++;
      end
    endfunction

    function void end_word();
      byte_q_t     wb, key, e;
      int          offs[$];
      logic [19:0] pieces[$];
      logic [19:0] id;
      int          start, stop;
      bit          hit, miss;
      word_n = 0;
      if (char_cnt == 0 || emitted >= out_cap) return;
      if (char_cnt > MAX_WORD_CHARS_DEF) begin
        emit_id(unk_id);
      end else begin
        offs.push_back(0);
        for (int i = 0; i < char_cnt; i++) begin
          e = utf8_bytes(chars[i]);
          foreach (e[k]) wb.push_back(e[k]);
          offs.push_back(wb.size());
        end
        start = 0;
        miss  = 0;
        while (start < char_cnt && !miss) begin
          stop = char_cnt;
          hit  = 0;
          while (start < stop && !hit) begin
            key.delete();
            if (start > 0) begin
              key.push_back(HASH_CHAR);
              key.push_back(HASH_CHAR);
            end
            for (int b = offs[start]; b < offs[stop]; b++) key.push_back(wb[b]);
            if (find_piece(key, id)) hit = 1;
            else stop--;
          end
          if (!hit) begin
            emit_id(unk_id);
            pieces.delete();
            miss = 1;
          end else begin
            pieces.push_back(id);
            start = stop;
          end
        end
        foreach (pieces[i]) emit_id(pieces[i]);
      end
      if (word_n > 0) expected_ids[expected_ids.size() - 1].last = 1'b1;
    endfunction

    // accepted input beat
    function void note(in_item_t it);
      case (it.cmd)
        CMD_WRITE_SLOT: begin
          if (it.addr < SLOTS_DEF)
            slots[it.addr[15:0]] = '{it.slot_used, it.slot_length, it.slot_offset,
                                     it.slot_token};
        end
        CMD_WRITE_BYTE: vocab[int'(it.addr)] = it.token_byte;
        CMD_PUSH_CHAR: begin
          if (char_cnt < MAX_WORD_CHARS_DEF) chars[char_cnt++] = it.code_point;
          else char_cnt = MAX_WORD_CHARS_DEF + 1;
        end
        CMD_END_WORD: begin
          end_word();
          char_cnt = 0;
        end
        CMD_START_SEQ: begin
          emitted  = 0;
          char_cnt = 0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    // accepted output beat
    task check(out_item_t got);
      out_item_t want;
      if (expected_ids.size() == 0) begin
        report($sformatf("unexpected id %h last %b", got.token_id, got.last));
      end else begin
        want = expected_ids.pop_front();
        if (got.token_id !== want.token_id)
          report($sformatf("token_id %h, want %h", got.token_id, want.token_id));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b (id %h)", got.last, want.last, want.token_id));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [19:0] cfg_data;

  wordpiece_scoreboard sb;
  int  burst_left;
  int  vocab_top;
  int  idle_cycles;
  int  rand_count;
  bit  hold_req;

  wordpiece_longest_match uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // output side: check every accepted beat
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check(out_data);
  end

  // watchdog on cycles without any accepted beat; covers the clearing sweep
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver stall pattern: stretches of no stall, light and heavy stall,
  // and one long hold-off on request so the block backs up into its input
  initial begin : receiver
    int mode, left;
    bit held;
    out_stall = 1'b0;
    mode      = 0;
    left      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // random filler for every field, so that unused fields toggle too
  function automatic in_item_t noise_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // one input beat; bursts of random length with random gaps between them
  task send(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  endtask

  task send_cmd(logic [2:0] cmd);
    in_item_t it;
    it     = noise_item();
    it.cmd = cmd;
    send(it);
  endtask

  task push_char(logic [20:0] cp);
    in_item_t it;
    it            = noise_item();
    it.cmd        = CMD_PUSH_CHAR;
    it.code_point = cp;
    send(it);
  endtask

  task write_byte(int a, logic [7:0] b);
    in_item_t it;
    it            = noise_item();
    it.cmd        = CMD_WRITE_BYTE;
    it.addr       = 18'(a);
    it.token_byte = b;
    send(it);
  endtask

  task write_slot(int a, logic [8:0] len, int off, logic [19:0] tok);
    in_item_t it;
    it             = noise_item();
    it.cmd         = CMD_WRITE_SLOT;
    it.addr        = 18'(a);
    it.slot_used   = 1'b1;
    it.slot_length = len;
    it.slot_offset = 18'(off);
    it.slot_token  = tok;
    send(it);
  endtask

  // free slot on the probe path of a key, or -1 when the table is full
  function automatic int free_slot(byte_q_t key);
    logic [63:0] h, idx;
    h = sb.fnv_hash(key);
    for (longint i = 0; i <= sb.slot_mask; i++) begin
      idx = (h + i) & {48'd0, sb.slot_mask};
      if (!sb.slots[idx[15:0]].used) return int'(idx[15:0]);
    end
    return -1;
  endfunction

  task automatic add_piece(cp_q_t cps, bit cont);
    byte_q_t key, e;
    int      s;
    if (cont) begin
      key.push_back(HASH_CHAR);
      key.push_back(HASH_CHAR);
    end
    foreach (cps[i]) begin
      e = sb.utf8_bytes(cps[i]);
      foreach (e[k]) key.push_back(e[k]);
    end
    s = free_slot(key);
    if (s >= 0) begin
      foreach (key[k]) write_byte(vocab_top + k, key[k]);
      write_slot(s, 9'(key.size()), vocab_top, 20'($urandom_range(1, 20'hFFFFF)));
      vocab_top += key.size();
    end
  endtask

  // ascii, two-, three- and four-byte letters
  function automatic logic [20:0] letter();
    case ($urandom_range(0, 5))
      0: return 21'h61;
      1: return 21'h62;
      2: return 21'h6E;
      3: return 21'hE9;
      4: return 21'h4E2D;
      default: return 21'h1F600;
    endcase
  endfunction

  task load_vocab(int count);
    cp_q_t cps;
    cps = '{21'h61};
    add_piece(cps, 0);
    add_piece(cps, 1);
    repeat (count) begin
      cps.delete();
      repeat ($urandom_range(1, 3)) cps.push_back(letter());
      add_piece(cps, $urandom_range(0, 1));
    end
  endtask

  task end_word();
    send_cmd(CMD_END_WORD);
  endtask

  task word_of(int n, logic [20:0] cp);
    repeat (n) push_char(cp);
    end_word();
  endtask

  // wait until every expected id is out and the block has settled
  task drain();
    in_valid <= 1'b0;
    while (sb.expected_ids.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_regs(logic [15:0] mask, logic [19:0] unk, logic [15:0] cap);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SLOT_MASK;
    cfg_data <= {4'd0, mask};
    sb.write_reg(CFG_SLOT_MASK, {4'd0, mask});
    @(posedge clk);
    cfg_idx  <= CFG_UNKNOWN_ID;
    cfg_data <= unk;
    sb.write_reg(CFG_UNKNOWN_ID, unk);
    @(posedge clk);
    cfg_idx  <= CFG_OUT_CAPACITY;
    cfg_data <= {4'd0, cap};
    sb.write_reg(CFG_OUT_CAPACITY, {4'd0, cap});
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly well-formed words, some noise and broken sequences
  task random_items(int target);
    in_item_t it;
    int       n;
    rand_count = 0;
    while (rand_count < target) begin
      case ($urandom_range(0, 19))
        0: begin
          send_cmd(CMD_START_SEQ);
          rand_count++;
        end
        1: begin
          // slot write that the block ignores, or one that frees a slot
          it = noise_item();
          it.cmd = CMD_WRITE_SLOT;
          if ($urandom_range(0, 1)) it.addr = 18'($urandom_range(SLOTS_DEF, 18'h3FFFF));
          else it.slot_used = 1'b0;
          send(it);
          rand_count++;
        end
        2: begin
          it = noise_item();
          it.cmd = CMD_WRITE_BYTE;
          send(it);
          rand_count++;
        end
        3: begin
          // long slot string that no key can reach
          it = noise_item();
          it.cmd = CMD_WRITE_SLOT;
          it.slot_length = 9'($urandom_range(403, 511));
          send(it);
          rand_count++;
        end
        4: begin
          send_cmd(CMD_SPARE + 3'($urandom_range(0, 2)));
          rand_count++;
        end
        5: begin
          // word cut short by a new sequence
          push_char(letter());
          send_cmd(CMD_START_SEQ);
          rand_count += 2;
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) push_char(21'($urandom_range(0, 21'h1FFFFF)));
            else push_char(letter());
          end
          end_word();
          rand_count += n + 1;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_SLOT_MASK;
    cfg_data    = '0;
    hold_req    = 1'b0;
    burst_left  = 0;
    vocab_top   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first setting: 256 slots, all-ones unknown id
    write_regs(16'd255, 20'hFFFFF, 16'hFFFF);
    load_vocab(10);

    // directed part
    it = noise_item();
    it.cmd  = CMD_WRITE_SLOT;
    it.addr = 18'h3FFFF;                     // slot index out of range
    send(it);
    send_cmd(CMD_SPARE);
    send_cmd(CMD_SPARE + 3'd2);
    end_word();                              // empty word
    word_of(1, 21'h61);
    push_char(21'h0);
    push_char(21'h7F);
    push_char(21'h80);
    push_char(21'h7FF);
    push_char(21'h800);
    push_char(21'hD800);                     // surrogate
    push_char(21'hFFFE);
    push_char(21'h10000);
    push_char(21'h10FFFF);
    push_char(21'h1FFFFF);                   // above the unicode range
    end_word();
    // token string running off the end of the byte store
    write_byte(18'h3FFFF, 8'hC3);
    it = noise_item();
    begin
      byte_q_t key;
      key = sb.utf8_bytes(21'h62);
      key.push_back(8'h62);
      if (free_slot(key) >= 0) write_slot(free_slot(key), 9'd2, 18'h3FFFF, 20'h12345);
    end
    word_of(2, 21'h62);
    push_char(21'h61);
    send_cmd(CMD_START_SEQ);                 // drops the partial word
    word_of(1, 21'h62);
    word_of(101, 21'h61);                    // overlong
    word_of(100, 21'h3000);                  // longest word, no piece matches
    word_of(66, 21'h61);                     // more pieces than the result limit

    hold_req <= 1'b1;                        // long receiver hold-off
    random_items(30);
    drain();

    // one slot only, zero unknown id, small capacity
    write_regs(16'd0, 20'd0, 16'd7);
    load_vocab(2);
    send_cmd(CMD_START_SEQ);
    random_items(15);
    drain();

    // full table, capacity zero: nothing comes out
    write_regs(16'hFFFF, 20'hABCDE, 16'd0);
    load_vocab(4);
    send_cmd(CMD_START_SEQ);
    random_items(10);
    drain();

    // four slots, random unknown id, medium capacity
    write_regs(16'd3, 20'($urandom_range(0, 20'hFFFFF)), 16'd40);
    load_vocab(3);
    send_cmd(CMD_START_SEQ);
    random_items(25);
    drain();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
